@@ rtl/stlac_pkg.sv @@
// Package for the smoke, temperature and light auto controller.
// Holds beat layouts, register indexes, reset values and the config bundle.
// No dependencies.
package stlac_pkg;

   localparam int ReqDataW = 48;
   localparam int RspDataW = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   typedef enum logic [CsrIdxW-1:0] {
      REG_SMOKE_LEVEL    = 3'd0,
      REG_FAN_HOLD       = 3'd1,
      REG_ALERT_INTERVAL = 3'd2,
      REG_FAULT_TIMEOUT  = 3'd3,
      REG_TEMP_ON        = 3'd4,
      REG_TEMP_OFF       = 3'd5,
      REG_LED_OFF_DELAY  = 3'd6
   } reg_idx_type;

   localparam logic              RstSmokeLevel    = 1'b0;
   localparam logic [15:0]       RstFanHold       = 16'd30;
   localparam logic [15:0]       RstAlertInterval = 16'd10;
   localparam logic [15:0]       RstFaultTimeout  = 16'd60;
   localparam logic signed [7:0] RstTempOn        = 8'sd32;
   localparam logic signed [7:0] RstTempOff       = 8'sd30;
   localparam logic [15:0]       RstLedOffDelay   = 16'd30;

   typedef struct packed {
      logic              smoke_level;
      logic [15:0]       fan_hold_seconds;
      logic [15:0]       alert_interval_seconds;
      logic [15:0]       fault_timeout_seconds;
      logic signed [7:0] temp_on_level;
      logic signed [7:0] temp_off_level;
      logic [15:0]       led_off_delay_seconds;
   } cfg_type;

   typedef struct packed {
      logic              smoke;
      logic              smoke_ok;
      logic signed [7:0] temperature;
      logic              temp_ok;
      logic              dark;
      logic              light_ok;
      logic              motion;
      logic              pir_ok;
      logic [31:0]       now_seconds;
   } req_type;

   typedef struct packed {
      logic sensor_fault;
      logic fault_alert;
      logic smoke_warn;
      logic led_on;
      logic fan_on;
   } rsp_type;

   // elapsed seconds, zero when time ran backwards
   function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] mark);
      since = (now >= mark) ? (now - mark) : 32'd0;
   endfunction

endpackage

@@ rtl/stlac_cfg.sv @@
// Configuration register file of the auto controller.
// Depends on stlac_pkg.
module stlac_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [stlac_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [stlac_pkg::CsrDataW-1:0]  csr_wdata,
   output stlac_pkg::cfg_type              cfg
);

   stlac_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (stlac_pkg::reg_idx_type'(csr_index))
            stlac_pkg::REG_SMOKE_LEVEL:    cfg_in.smoke_level = csr_wdata[0];
            stlac_pkg::REG_FAN_HOLD:       cfg_in.fan_hold_seconds = csr_wdata;
            stlac_pkg::REG_ALERT_INTERVAL: cfg_in.alert_interval_seconds = csr_wdata;
            stlac_pkg::REG_FAULT_TIMEOUT:  cfg_in.fault_timeout_seconds = csr_wdata;
            stlac_pkg::REG_TEMP_ON:        cfg_in.temp_on_level = csr_wdata[7:0];
            stlac_pkg::REG_TEMP_OFF:       cfg_in.temp_off_level = csr_wdata[7:0];
            stlac_pkg::REG_LED_OFF_DELAY:  cfg_in.led_off_delay_seconds = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoke_level            <= stlac_pkg::RstSmokeLevel;
         cfg_ff.fan_hold_seconds       <= stlac_pkg::RstFanHold;
         cfg_ff.alert_interval_seconds <= stlac_pkg::RstAlertInterval;
         cfg_ff.fault_timeout_seconds  <= stlac_pkg::RstFaultTimeout;
         cfg_ff.temp_on_level          <= stlac_pkg::RstTempOn;
         cfg_ff.temp_off_level         <= stlac_pkg::RstTempOff;
         cfg_ff.led_off_delay_seconds  <= stlac_pkg::RstLedOffDelay;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/stlac_ctrl.sv @@
// Control state and per-sample decision logic (smoke, fault, fan, LED).
// Updates state on each processed beat. Depends on stlac_pkg.
module stlac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  stlac_pkg::req_type   req,
   input  stlac_pkg::cfg_type   cfg,
   output stlac_pkg::rsp_type   rsp
);

   logic        alarm_active_ff, alarm_active_in;
   logic [31:0] alarm_start_ff, alarm_start_in;
   logic        fault_flag_ff, fault_flag_in;
   logic [31:0] last_fault_ff, last_fault_in;
   logic [31:0] last_smoke_ff, last_smoke_in;
   logic [31:0] hold_until_ff, hold_until_in;
   logic        fan_ff, fan_in;
   logic        led_ff, led_in;
   logic        idle_timing_ff, idle_timing_in;
   logic [31:0] idle_start_ff, idle_start_in;

   logic        smoke_alarm;
   logic        smoke_pulse, fault_pulse;
   logic        fan_mid;
   logic [31:0] now;
   logic [31:0] start_eff, last_fault_eff, idle_eff;
   logic [32:0] hold_sum;
   logic [31:0] hold_end;

   always_comb begin
      now         = req.now_seconds;
      smoke_alarm = req.smoke_ok && (req.smoke == cfg.smoke_level);
      smoke_pulse = 1'b0;
      fault_pulse = 1'b0;

      alarm_active_in = alarm_active_ff;
      alarm_start_in  = alarm_start_ff;
      fault_flag_in   = fault_flag_ff;
      last_fault_in   = last_fault_ff;
      last_smoke_in   = last_smoke_ff;
      hold_until_in   = hold_until_ff;
      fan_mid         = fan_ff;
      led_in          = led_ff;
      idle_timing_in  = idle_timing_ff;
      idle_start_in   = idle_start_ff;

      start_eff      = alarm_active_ff ? alarm_start_ff : now;
      last_fault_eff = fault_flag_ff ? last_fault_ff : now;
      hold_sum       = {1'b0, now} + {17'd0, cfg.fan_hold_seconds};
      hold_end       = hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];

      if (req.smoke_ok) begin
         if (smoke_alarm) begin
            alarm_active_in = 1'b1;
            alarm_start_in  = start_eff;
            if (stlac_pkg::since(now, start_eff) >= {16'd0, cfg.fault_timeout_seconds}) begin
               fault_flag_in = 1'b1;
               if (!fault_flag_ff) begin
                  fault_pulse   = 1'b1;
                  last_fault_in = now;
               end
               if (stlac_pkg::since(now, last_fault_eff) >
                   {16'd0, cfg.alert_interval_seconds}) begin
                  fault_pulse   = 1'b1;
                  last_fault_in = now;
               end
            end else begin
               fan_mid       = 1'b1;
               hold_until_in = hold_end;
               if (stlac_pkg::since(now, last_smoke_ff) >
                   {16'd0, cfg.alert_interval_seconds}) begin
                  smoke_pulse   = 1'b1;
                  last_smoke_in = now;
               end
            end
         end else begin
            alarm_active_in = 1'b0;
            fault_flag_in   = 1'b0;
            if (fan_ff && now >= hold_until_ff)
               fan_mid = 1'b0;
         end
      end

      // hold is unchanged whenever this branch can run
      fan_in = fan_mid;
      if (req.temp_ok && !smoke_alarm && now >= hold_until_ff) begin
         if (req.temperature > cfg.temp_on_level && !fan_mid)
            fan_in = 1'b1;
         else if (req.temperature < cfg.temp_off_level && fan_mid)
            fan_in = 1'b0;
      end

      idle_eff = idle_timing_ff ? idle_start_ff : now;
      if (req.light_ok && req.pir_ok) begin
         if (req.dark && req.motion) begin
            led_in         = 1'b1;
            idle_timing_in = 1'b0;
         end else if (!req.motion) begin
            idle_timing_in = 1'b1;
            idle_start_in  = idle_eff;
            if (led_ff && stlac_pkg::since(now, idle_eff) >=
                {16'd0, cfg.led_off_delay_seconds})
               led_in = 1'b0;
         end
      end

      rsp.fan_on       = fan_in;
      rsp.led_on       = led_in;
      rsp.smoke_warn   = smoke_pulse;
      rsp.fault_alert  = fault_pulse;
      rsp.sensor_fault = fault_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_active_ff <= 1'b0;
         alarm_start_ff  <= '0;
         fault_flag_ff   <= 1'b0;
         last_fault_ff   <= '0;
         last_smoke_ff   <= '0;
         hold_until_ff   <= '0;
         fan_ff          <= 1'b0;
         led_ff          <= 1'b0;
         idle_timing_ff  <= 1'b0;
         idle_start_ff   <= '0;
      end else if (step) begin
         alarm_active_ff <= alarm_active_in;
         alarm_start_ff  <= alarm_start_in;
         fault_flag_ff   <= fault_flag_in;
         last_fault_ff   <= last_fault_in;
         last_smoke_ff   <= last_smoke_in;
         hold_until_ff   <= hold_until_in;
         fan_ff          <= fan_in;
         led_ff          <= led_in;
         idle_timing_ff  <= idle_timing_in;
         idle_start_ff   <= idle_start_in;
      end
   end

endmodule

@@ rtl/smoke_temp_light_auto_control.sv @@
// Top level of the smoke, temperature and light auto controller.
// Depends on stlac_pkg, stlac_cfg and stlac_ctrl.
//
// One sensor sample beat in gives one result beat out. A sample is held in
// an input register, decided combinationally against the controller state
// and written to an output register, so a result beat is offered once its
// sample has passed both registers; a new sample can be taken every cycle
// while the result side is not stalled, so the rate is one beat per cycle.
// Both registers advance whenever the result register is empty or being read.
// The user writes registers through csr_we/csr_index/csr_wdata only while no
// sample is in flight; the block itself does not enforce this. Index 7 is
// ignored.
module smoke_temp_light_auto_control (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_seconds[31:0], pir_ok, motion, light_ok, dark, temp_ok,
   // temperature[7:0], smoke_ok, smoke, zero pad
   input  logic [stlac_pkg::ReqDataW-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // fan_on, led_on, smoke_warn, fault_alert, sensor_fault, zero pad
   output logic [stlac_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [stlac_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [stlac_pkg::CsrDataW-1:0]   csr_wdata
);

   stlac_pkg::cfg_type cfg;
   stlac_pkg::req_type req_beat;
   stlac_pkg::req_type smp_ff;
   stlac_pkg::rsp_type res;
   stlac_pkg::rsp_type rsp_ff;
   logic               smp_valid_ff;
   logic               rsp_valid_ff;
   logic               out_free;
   logic               step;

   assign req_beat = stlac_pkg::req_type'(req_tdata[46:0]);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = smp_valid_ff && out_free;
   assign req_tready = !smp_valid_ff || step;

   stlac_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   stlac_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (smp_ff),
      .cfg   (cfg),
      .rsp   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready)
            smp_valid_ff <= req_tvalid;
         if (out_free)
            rsp_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready)
         smp_ff <= req_beat;
      if (step)
         rsp_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

endmodule

@@ tb/stlac_checker.sv @@
// Scoreboard for the smoke, temperature and light auto controller.
// Tracks register writes, predicts one result per accepted sample beat and
// compares result beats in order. Depends on stlac_pkg.
module stlac_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [stlac_pkg::ReqDataW-1:0]   req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [stlac_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [stlac_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [stlac_pkg::CsrDataW-1:0]   csr_wdata,
   output int                               errors,
   output int                               outstanding,
   output int                               checked,
   output int                               smoke_warns,
   output int                               fault_alerts
);
   timeunit 1ns;
   timeprecision 1ps;
   import stlac_pkg::*;

   cfg_type     cfg;
   bit          alarm_on, fault_set, fan, led, idle_run;
   logic [31:0] alarm_t0, fault_alert_t, smoke_alert_t, hold_end, idle_t0;
   rsp_type     drive_q[$];
   int          n_err = 0, n_checked = 0, n_smoke = 0, n_fault = 0;

   function automatic logic [31:0] elapsed(input logic [31:0] t, input logic [31:0] mark);
      return (t >= mark) ? t - mark : 32'd0;
   endfunction

   task automatic apply_sample(input req_type s, output rsp_type r);
      bit                alarm;
      logic [31:0]       t;
      logic [32:0]       hold_sum;
      logic signed [7:0] temp, on_lvl, off_lvl;
      t       = s.now_seconds;
      temp    = s.temperature;
      on_lvl  = cfg.temp_on_level;
      off_lvl = cfg.temp_off_level;
      alarm   = s.smoke_ok && (s.smoke == cfg.smoke_level);
      r       = '0;

      if (s.smoke_ok) begin
         if (alarm) begin
            if (!alarm_on) begin
               alarm_on = 1'b1;
               alarm_t0 = t;
            end
            if (elapsed(t, alarm_t0) >= {16'd0, cfg.fault_timeout_seconds}) begin
               if (!fault_set) begin
                  fault_set     = 1'b1;
                  r.fault_alert = 1'b1;
                  fault_alert_t = t;
               end
               if (elapsed(t, fault_alert_t) > {16'd0, cfg.alert_interval_seconds}) begin
                  r.fault_alert = 1'b1;
                  fault_alert_t = t;
               end
            end else begin
               fan      = 1'b1;
               hold_sum = {1'b0, t} + {17'd0, cfg.fan_hold_seconds};
               hold_end = hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];
               if (elapsed(t, smoke_alert_t) > {16'd0, cfg.alert_interval_seconds}) begin
                  r.smoke_warn  = 1'b1;
                  smoke_alert_t = t;
               end
            end
         end else begin
            alarm_on  = 1'b0;
            fault_set = 1'b0;
            if (fan && t >= hold_end) fan = 1'b0;
         end
      end

      if (s.temp_ok && !alarm && t >= hold_end) begin
         if (temp > on_lvl && !fan) fan = 1'b1;
         else if (temp < off_lvl && fan) fan = 1'b0;
      end

      if (s.light_ok && s.pir_ok) begin
         if (s.dark && s.motion) begin
            led      = 1'b1;
            idle_run = 1'b0;
         end else if (!s.motion) begin
            if (!idle_run) begin
               idle_run = 1'b1;
               idle_t0  = t;
            end
            if (led && elapsed(t, idle_t0) >= {16'd0, cfg.led_off_delay_seconds}) led = 1'b0;
         end
      end

      r.fan_on       = fan;
      r.led_on       = led;
      r.sensor_fault = fault_set;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want, got;
      if (reset) begin
         cfg = '{RstSmokeLevel, RstFanHold, RstAlertInterval, RstFaultTimeout,
                 RstTempOn, RstTempOff, RstLedOffDelay};
         alarm_on      = 1'b0;
         fault_set     = 1'b0;
         fan           = 1'b0;
         led           = 1'b0;
         idle_run      = 1'b0;
         alarm_t0      = '0;
         fault_alert_t = '0;
         smoke_alert_t = '0;
         hold_end      = '0;
         idle_t0       = '0;
         drive_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SMOKE_LEVEL:    cfg.smoke_level            = csr_wdata[0];
               REG_FAN_HOLD:       cfg.fan_hold_seconds       = csr_wdata;
               REG_ALERT_INTERVAL: cfg.alert_interval_seconds = csr_wdata;
               REG_FAULT_TIMEOUT:  cfg.fault_timeout_seconds  = csr_wdata;
               REG_TEMP_ON:        cfg.temp_on_level          = csr_wdata[7:0];
               REG_TEMP_OFF:       cfg.temp_off_level         = csr_wdata[7:0];
               REG_LED_OFF_DELAY:  cfg.led_off_delay_seconds  = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            n_checked++;
            if (drive_q.size() == 0) begin
               n_err++;
               $display("%0t: result beat with nothing expected, got %b", $time, got);
            end else begin
               want = drive_q.pop_front();
               if (got !== want) begin
                  n_err++;
                  $display({"%0t: expected fan=%b led=%b smoke_warn=%b fault_alert=%b ",
                            "fault=%b, got fan=%b led=%b smoke_warn=%b fault_alert=%b ",
                            "fault=%b"}, $time,
                           want.fan_on, want.led_on, want.smoke_warn,
                           want.fault_alert, want.sensor_fault,
                           got.fan_on, got.led_on, got.smoke_warn,
                           got.fault_alert, got.sensor_fault);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            apply_sample(req_tdata[$bits(req_type)-1:0], want);
            drive_q.push_back(want);
            n_smoke += want.smoke_warn;
            n_fault += want.fault_alert;
         end
      end

      errors       <= n_err;
      outstanding  <= drive_q.size();
      checked      <= n_checked;
      smoke_warns  <= n_smoke;
      fault_alerts <= n_fault;
   end

endmodule

@@ tb/tb.sv @@
// Top of the testbench for the smoke, temperature and light auto controller.
// Drives reset, register settings and sample beats, stalls the result side,
// and gives the verdict. Depends on stlac_pkg, the RTL top and stlac_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stlac_pkg::*;

   localparam int                 CycleLimit = 200000;
   localparam int                 PhaseItems = 229;
   localparam int                 Phases     = 8;
   localparam int                 QuietPhase = 3;
   localparam logic [CsrIdxW-1:0] RegSpare   = 3'd7;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we     = 1'b0;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0] csr_wdata  = '0;

   int errors, outstanding, checked, smoke_warns, fault_alerts;
   int cycle_count  = 0;
   int samples_sent = 0;
   bit quiet        = 1'b0;

   cfg_type     active_cfg;
   logic [31:0] now_s;
   int          temp_walk, smoke_run, light_run;
   bit          smoke_hot, motion_s, dark_s;

   smoke_temp_light_auto_control i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   stlac_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .errors       (errors),
      .outstanding  (outstanding),
      .checked      (checked),
      .smoke_warns  (smoke_warns),
      .fault_alerts (fault_alerts)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) rsp_tready <= quiet || ($urandom_range(0, 99) >= 6);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_sample(input req_type s);
      while (!quiet && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= ReqDataW'(s);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic put(input logic [31:0] t, input bit pir_ok, input bit motion,
                      input bit light_ok, input bit dark, input bit temp_ok,
                      input logic signed [7:0] temp, input bit smoke_ok, input bit smoke);
      req_type s;
      s = '{smoke, smoke_ok, temp, temp_ok, dark, light_ok, motion, pir_ok, t};
      send_sample(s);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= REG_SMOKE_LEVEL;
      csr_wdata <= {15'($urandom), c.smoke_level};
      @(posedge clock);
      csr_index <= REG_FAN_HOLD;
      csr_wdata <= c.fan_hold_seconds;
      @(posedge clock);
      csr_index <= RegSpare;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_index <= REG_ALERT_INTERVAL;
      csr_wdata <= c.alert_interval_seconds;
      @(posedge clock);
      csr_index <= REG_FAULT_TIMEOUT;
      csr_wdata <= c.fault_timeout_seconds;
      @(posedge clock);
      csr_index <= REG_TEMP_ON;
      csr_wdata <= {8'($urandom), c.temp_on_level};
      @(posedge clock);
      csr_index <= REG_TEMP_OFF;
      csr_wdata <= {8'($urandom), c.temp_off_level};
      @(posedge clock);
      csr_index <= REG_LED_OFF_DELAY;
      csr_wdata <= c.led_off_delay_seconds;
      @(posedge clock);
      csr_we    <= 1'b0;
      active_cfg = c;
   endtask

   function automatic logic [15:0] pick_seconds(input int hi);
      return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, hi));
   endfunction

   task automatic pick_settings(input int phase, output cfg_type c);
      if (phase == 0) begin
         c = '{1'b1, 16'd0, 16'd0, 16'd0, -8'sd128, -8'sd128, 16'd0};
      end else if (phase == 1) begin
         c = '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'sd127, 8'sd127, 16'hFFFF};
      end else begin
         c.smoke_level            = 1'($urandom_range(0, 1));
         c.fan_hold_seconds       = pick_seconds(60);
         c.alert_interval_seconds = pick_seconds(20);
         c.fault_timeout_seconds  = pick_seconds(120);
         c.led_off_delay_seconds  = pick_seconds(60);
         if ($urandom_range(0, 4) == 0) begin
            c.temp_on_level  = 8'($urandom);
            c.temp_off_level = 8'($urandom);
         end else begin
            c.temp_on_level  = 8'($urandom_range(5, 45));
            c.temp_off_level = c.temp_on_level - 8'($urandom_range(0, 6));
         end
      end
   endtask

   task automatic next_sample(output req_type s);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2)      now_s = now_s - $urandom_range(1, 50);
      else if (r < 5) now_s = now_s + $urandom_range(0, 200000);
      else if (r < 6) now_s = 32'hFFFF_FFFF - $urandom_range(0, 300);
      else            now_s = now_s + $urandom_range(0, 4);

      if (smoke_run == 0) begin
         smoke_hot = 1'($urandom_range(0, 1));
         smoke_run = smoke_hot ? $urandom_range(1, 40) : $urandom_range(1, 25);
      end
      smoke_run--;
      if (light_run == 0) begin
         motion_s  = 1'($urandom_range(0, 1));
         light_run = $urandom_range(1, 30);
      end
      light_run--;
      if ($urandom_range(0, 9) == 0) dark_s = !dark_s;

      temp_walk = temp_walk + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 19) == 0) temp_walk = int'($urandom_range(0, 255)) - 128;
      if (temp_walk > 127) temp_walk = 127;
      if (temp_walk < -128) temp_walk = -128;

      s.now_seconds = now_s;
      s.pir_ok      = $urandom_range(0, 99) >= 7;
      s.motion      = motion_s;
      s.light_ok    = $urandom_range(0, 99) >= 7;
      s.dark        = dark_s;
      s.temp_ok     = $urandom_range(0, 99) >= 7;
      s.temperature = temp_walk[7:0];
      s.smoke_ok    = $urandom_range(0, 99) >= 5;
      s.smoke       = smoke_hot ? active_cfg.smoke_level : !active_cfg.smoke_level;
      // noise beat: flags scrambled
      if ($urandom_range(0, 19) == 0)
         {s.pir_ok, s.motion, s.light_ok, s.dark, s.temp_ok, s.smoke_ok, s.smoke} = 7'($urandom);
   endtask

   initial begin
      cfg_type c;
      req_type s;
      active_cfg = '{RstSmokeLevel, RstFanHold, RstAlertInterval, RstFaultTimeout,
                     RstTempOn, RstTempOff, RstLedOffDelay};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: smoke reads 0 at the alert level
      put(32'd0,   0, 0, 0, 0, 0, 8'sd0,    0, 0);  // nothing valid
      put(32'd1,   1, 1, 1, 0, 0, 8'sd0,    0, 1);  // bright with motion
      put(32'd5,   1, 1, 1, 1, 0, 8'sd0,    0, 1);  // dark with motion
      put(32'd6,   1, 0, 1, 1, 0, 8'sd0,    0, 1);
      put(32'd35,  1, 0, 1, 0, 0, 8'sd0,    0, 1);
      put(32'd36,  1, 0, 0, 1, 0, 8'sd0,    0, 1);  // light invalid
      put(32'd36,  1, 0, 1, 1, 0, 8'sd0,    0, 1);  // led off delay reached
      put(32'd40,  0, 0, 0, 0, 1, 8'sd127,  1, 1);
      put(32'd41,  0, 0, 0, 0, 1, -8'sd128, 0, 0);
      put(32'd100, 0, 0, 0, 0, 0, 8'sd0,    1, 0);  // smoke
      put(32'd105, 0, 0, 0, 0, 1, -8'sd128, 1, 0);
      put(32'd111, 0, 0, 0, 0, 0, 8'sd0,    1, 0);
      put(32'd120, 0, 0, 0, 0, 0, 8'sd0,    1, 1);  // clear, hold running
      put(32'd125, 0, 0, 0, 0, 1, -8'sd128, 0, 0);
      put(32'd141, 0, 0, 0, 0, 0, 8'sd0,    1, 1);  // hold expired
      put(32'd200, 0, 0, 0, 0, 0, 8'sd0,    1, 0);
      put(32'd260, 0, 0, 0, 0, 0, 8'sd0,    1, 0);  // fault entry
      put(32'd265, 0, 0, 0, 0, 0, 8'sd0,    1, 0);
      put(32'd276, 0, 0, 0, 0, 0, 8'sd0,    1, 0);  // periodic fault alert
      put(32'd100, 0, 0, 0, 0, 0, 8'sd0,    1, 0);  // time backwards
      put(32'd150, 0, 0, 0, 0, 0, 8'sd0,    1, 1);
      put(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 8'sd0, 1, 1);
      put(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 8'sd0, 1, 0); // hold end saturates
      put(32'hFFFF_FFFF, 1, 1, 1, 1, 1, 8'sh55, 1, 1);
      drain();

      for (int p = 0; p < Phases; p++) begin
         pick_settings(p, c);
         apply_settings(c);
         quiet     <= (p == QuietPhase);
         now_s      = $urandom_range(0, 1000);
         temp_walk  = int'(c.temp_off_level);
         smoke_run  = 0;
         light_run  = 0;
         repeat (PhaseItems) begin
            next_sample(s);
            send_sample(s);
         end
         drain();
      end

      $display("Sent %0d sensor samples under %0d register settings, %0d results compared",
               samples_sent, Phases + 1, checked);
      $display("Alert pulses predicted: %0d smoke, %0d fault", smoke_warns, fault_alerts);
      if (errors == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
